// File: rtl/prl_pkg.sv
// Shared types and constants for the per-client rate limiter.
package prl_pkg;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MINUTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOUR   = 2'd2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic        ENABLED_RST    = 1'b1;
    localparam logic [15:0] MAX_MINUTE_RST = 16'd60;
    localparam logic [19:0] MAX_HOUR_RST   = 20'd1000;

    localparam logic [31:0] MINUTE_SECONDS = 32'd60;
    localparam logic [31:0] HOUR_SECONDS   = 32'd3600;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  client_id;
        logic [31:0] now_seconds;
    } prl_req_t;

    typedef struct packed {
        logic        allowed;
        logic [15:0] remaining;
    } prl_rsp_t;

    typedef struct packed {
        logic        enabled;
        logic [15:0] max_minute;
        logic [19:0] max_hour;
    } prl_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] minute_count;
        logic [19:0] hour_count;
        logic [31:0] minute_origin;
        logic [31:0] hour_origin;
    } prl_entry_t;

    typedef struct packed {
        logic       we;
        prl_entry_t entry;
        prl_rsp_t   rsp;
    } prl_upd_t;

endpackage

// File: rtl/prl_table.sv
// Client state table: one synchronous RAM with write-first bypass.
module prl_table #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  prl_pkg::prl_entry_t   wdata,
    input  logic                  re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output prl_pkg::prl_entry_t   rdata
);
    import prl_pkg::*;

    prl_entry_t mem [DEPTH];
    prl_entry_t mem_q_reg;
    prl_entry_t byp_data_reg;
    logic       byp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_q_reg <= mem[raddr];
        end
        byp_data_reg <= wdata;
    end

    // a read that meets a write to the same entry takes the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= re && we && (waddr == raddr);
        end
    end

    assign rdata = byp_reg ? byp_data_reg : mem_q_reg;

endmodule

// File: rtl/prl_update.sv
// Window roll-over, admission decision and entry update for one request.
module prl_update (
    input  prl_pkg::prl_req_t   req,
    input  logic                in_range,
    input  prl_pkg::prl_cfg_t   cfg,
    input  prl_pkg::prl_entry_t cur,
    output prl_pkg::prl_upd_t   upd
);
    import prl_pkg::*;

    prl_entry_t  opened;
    prl_entry_t  rolled;
    prl_entry_t  counted;
    logic [31:0] minute_age;
    logic [31:0] hour_age;
    logic        admit;
    logic [15:0] cur_quota;
    logic [15:0] new_quota;

    always_comb
    begin
        opened = cur;
        if (!cur.valid)
        begin
            opened.valid         = 1'b1;
            opened.minute_count  = '0;
            opened.hour_count    = '0;
            opened.minute_origin = req.now_seconds;
            opened.hour_origin   = req.now_seconds;
        end

        minute_age = req.now_seconds - opened.minute_origin;
        hour_age   = req.now_seconds - opened.hour_origin;

        rolled = opened;
        if (minute_age >= MINUTE_SECONDS)
        begin
            rolled.minute_count  = '0;
            rolled.minute_origin = req.now_seconds;
        end
        if (hour_age >= HOUR_SECONDS)
        begin
            rolled.hour_count  = '0;
            rolled.hour_origin = req.now_seconds;
        end

        admit = (rolled.minute_count < cfg.max_minute) && (rolled.hour_count < cfg.max_hour);

        counted = rolled;
        if (admit)
        begin
            counted.minute_count = rolled.minute_count + 16'd1;
            counted.hour_count   = rolled.hour_count + 20'd1;
        end
    end

    // minute quota left, floored at zero
    always_comb
    begin
        if (!cur.valid)
        begin
            cur_quota = cfg.max_minute;
        end
        else if (cur.minute_count >= cfg.max_minute)
        begin
            cur_quota = '0;
        end
        else
        begin
            cur_quota = cfg.max_minute - cur.minute_count;
        end

        if (counted.minute_count >= cfg.max_minute)
        begin
            new_quota = '0;
        end
        else
        begin
            new_quota = cfg.max_minute - counted.minute_count;
        end
    end

    always_comb
    begin
        upd.entry = counted;
        priority if (req.opcode == OP_RESET)
        begin
            upd.we            = in_range;
            upd.entry         = cur;
            upd.entry.valid   = 1'b0;
            upd.rsp.allowed   = 1'b0;
            upd.rsp.remaining = cfg.max_minute;
        end
        else if (!cfg.enabled)
        begin
            upd.we            = 1'b0;
            upd.rsp.allowed   = 1'b1;
            upd.rsp.remaining = in_range ? cur_quota : cfg.max_minute;
        end
        else if (!in_range)
        begin
            upd.we            = 1'b0;
            upd.rsp.allowed   = 1'b0;
            upd.rsp.remaining = '0;
        end
        else
        begin
            upd.we            = 1'b1;
            upd.rsp.allowed   = admit;
            upd.rsp.remaining = new_quota;
        end
    end

endmodule

// File: rtl/per_client_rate_limiter_top.sv
// Per-client two-window rate limiter: top level with config, pipeline and table clear.
// An accepted transaction has its entry read and updated in stage 1, and its result is
//   registered in the output stage (done high); one transaction per cycle is taken while
//   busy is low. The state RAM takes one read at accept and one write-back the cycle after.
// Reset clears the valid bit of every entry with a pass over the table; busy is high
//   meanwhile. Config writes are taken at any time. The receiver cannot stall.
module per_client_rate_limiter_top #(
    parameter int unsigned NUM_CLIENTS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  prl_pkg::prl_req_t                    req,
    output logic                                 done,
    output prl_pkg::prl_rsp_t                    rsp,
    input  logic                                 cfg_we,
    input  logic [prl_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [prl_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import prl_pkg::*;

    localparam int unsigned AW = $clog2(NUM_CLIENTS);

    // configuration registers
    prl_cfg_t cfg_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // stage 1: RAM read data arrives, entry is updated and written back
    logic          s1_valid_reg;
    prl_req_t      s1_req_reg;
    logic          s1_in_range_reg;
    logic [AW-1:0] s1_addr_reg;

    // output stage
    logic          done_reg;
    prl_rsp_t      rsp_reg;

    logic          accept;
    logic [16:0]   id_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;
    prl_entry_t    rd_entry;
    prl_upd_t      upd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    prl_entry_t    wr_data;

    assign busy   = clr_active_reg;
    assign accept = start && !clr_active_reg;

    // map the client index onto the table; indexes past the table are flagged
    assign id_ext   = {9'd0, req.client_id};
    assign in_addr  = id_ext[AW-1:0];
    assign in_range = id_ext < 17'(NUM_CLIENTS);

    // config writes: an index past the register list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled    <= ENABLED_RST;
            cfg_reg.max_minute <= MAX_MINUTE_RST;
            cfg_reg.max_hour   <= MAX_HOUR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ENABLED:    cfg_reg.enabled    <= cfg_wdata[0];
                CFG_MAX_MINUTE: cfg_reg.max_minute <= cfg_wdata[15:0];
                CFG_MAX_HOUR:   cfg_reg.max_hour   <= cfg_wdata[19:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // sweep the table once after reset, writing invalid entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= AW'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == AW'(NUM_CLIENTS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // hold the accepted transaction while its entry is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg      <= req;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
        end
    end

    // the table forwards a write-back to a read of the same entry at that edge,
    // so back-to-back transactions to one client see each other's update
    prl_table #(
        .DEPTH (NUM_CLIENTS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_entry)
    );

    prl_update u_update (
        .req      (s1_req_reg),
        .in_range (s1_in_range_reg),
        .cfg      (cfg_reg),
        .cur      (rd_entry),
        .upd      (upd)
    );

    // write port: the clearing pass owns it until done, then the update stage
    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_valid_reg && upd.we;
            wr_addr = s1_addr_reg;
            wr_data = upd.entry;
        end
    end

    // register the result; it is shown for exactly one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rsp_reg <= upd.rsp;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
